// File: sv/assert_macros.svh
// assertion macros shared by the priority queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define UAPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define UAPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/uapq_pkg.sv
// package with sizes, codes and control structs of the priority queue
package uapq_pkg;

    localparam int DEPTH    = 64;
    localparam int TAG_BITS = 16;
    localparam int PRIO_W   = 32;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ENTRY_W  = TAG_BITS + PRIO_W;

    typedef enum logic [2:0] {
        CMD_ENQ   = 3'd0,
        CMD_DEQ   = 3'd1,
        CMD_CHG   = 3'd2,
        CMD_CLR   = 3'd3,
        CMD_PEEK  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOTFOUND  = 3'd2,
        ST_NOTURGENT = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // latch input fields, restart scan index
        logic enq_write;  // append input entry
        logic clear;      // empty the table
        logic scan;       // issue reads and track best entry
        logic pick;       // load best entry into result, start shift
        logic shift;      // move later entries down one slot
        logic chg_write;  // rewrite priority of matched entry
        logic dec_count;  // drop one entry
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic scan_last;
        logic match;
        logic not_urgent;
        logic shift_done;
    } t_dp_sts;

endpackage

// File: sv/unsorted_array_priority_queue_core.sv
// top level of the unsorted table priority queue
//
// Input channel i_in_valid / o_in_ready carries one command (i_cmd, i_value_tag,
// i_prio_in); result channel o_out_valid / i_out_ready carries one result
// (o_status, o_out_tag, o_out_prio, o_occupancy) for every command.
// One command is in flight at a time; a new transfer is taken once the
// previous result has been taken.
// Path from input transfer to result valid:
//   enqueue, clear, unknown command, empty dequeue/peek/change: straight to result
//   peek: one-entry-per-cycle scan of all N entries, N the entry count, then pick
//   change priority: scan up to the first matching tag, or over the whole
//     table when the tag is absent
//   dequeue: scan, pick, then shift of the entries after the removed one;
//     scan and shift share one read port
// Synchronous active low reset empties the table at once; entry contents
// need no clearing. A stalled result holds on the outputs until taken.
module unsorted_array_priority_queue_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_cmd,
    input  logic [15:0]         i_value_tag,
    input  logic signed [31:0]  i_prio_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_status,
    output logic [15:0]         o_out_tag,
    output logic signed [31:0]  o_out_prio,
    output logic [6:0]          o_occupancy
);

    uapq_pkg::t_dp_cmd dp_cmd;
    uapq_pkg::t_dp_sts dp_sts;

    // sequencing of commands
    uapq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_dp_cmd    (dp_cmd),
        .i_dp_sts    (dp_sts)
    );

    // entry storage and scan
    uapq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_value_tag (i_value_tag),
        .i_prio_in   (i_prio_in),
        .o_sts       (dp_sts),
        .o_out_tag   (o_out_tag),
        .o_out_prio  (o_out_prio),
        .o_occupancy (o_occupancy)
    );

endmodule

// File: sv/uapq_datapath.sv
// datapath of the priority queue: entry memory, scan and shift logic
`include "assert_macros.svh"

module uapq_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  uapq_pkg::t_dp_cmd           i_cmd,
    input  logic [15:0]                 i_value_tag,
    input  logic signed [31:0]          i_prio_in,
    output uapq_pkg::t_dp_sts           o_sts,
    output logic [15:0]                 o_out_tag,
    output logic signed [31:0]          o_out_prio,
    output logic [6:0]                  o_occupancy
);

    localparam int TB = uapq_pkg::TAG_BITS;
    localparam int PW = uapq_pkg::PRIO_W;
    localparam int IW = uapq_pkg::IDX_W;
    localparam int CW = uapq_pkg::CNT_W;
    localparam int EW = uapq_pkg::ENTRY_W;

    logic [EW-1:0] r_mem [uapq_pkg::DEPTH];
    logic [EW-1:0] r_rd_data;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [IW-1:0] r_d_idx;
    logic          r_dv;
    logic [TB-1:0] r_tag;
    logic [PW-1:0] r_prio;
    logic [TB-1:0] r_best_tag;
    logic [PW-1:0] r_best_prio;
    logic [IW-1:0] r_best_idx;
    logic [TB-1:0] r_out_tag;
    logic [PW-1:0] r_out_prio;

    logic          issue;
    logic [TB-1:0] rd_tag;
    logic [PW-1:0] rd_prio;
    logic          rd_less;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    assign rd_tag  = r_rd_data[EW-1:PW];
    assign rd_prio = r_rd_data[PW-1:0];

    // read issue while the index is inside the table
    assign issue = (i_cmd.scan || i_cmd.shift) && (r_rd_idx < r_count);

    // smaller priority first, then smaller tag
    assign rd_less = ($signed(rd_prio) < $signed(r_best_prio)) ||
                     ((rd_prio == r_best_prio) && (rd_tag < r_best_tag));

    // status toward the controller
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.full       = (r_count == CW'(uapq_pkg::DEPTH));
    assign o_sts.scan_last  = r_dv && (r_d_idx == IW'(r_count - CW'(1)));
    assign o_sts.match      = r_dv && (rd_tag == r_tag);
    assign o_sts.not_urgent = ($signed(rd_prio) <= $signed(r_prio));
    assign o_sts.shift_done = (r_rd_idx >= r_count) && !r_dv;

    // write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IW-1:0];
        wr_data = {i_value_tag[TB-1:0], i_prio_in};
        priority if (i_cmd.enq_write) begin
            wr_en = 1'b1;
        end else if (i_cmd.chg_write) begin
            wr_en   = 1'b1;
            wr_addr = r_d_idx;
            wr_data = {r_tag, r_prio};
        end else if (i_cmd.shift && r_dv) begin
            wr_en   = 1'b1;
            wr_addr = r_d_idx - IW'(1);
            wr_data = r_rd_data;
        end
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_rd_idx[IW-1:0]];
    end

    // count and read index
    always_comb begin
        n_count = r_count;
        priority if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.enq_write) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.dec_count) begin
            n_count = r_count - CW'(1);
        end

        n_rd_idx = r_rd_idx;
        priority if (i_cmd.accept) begin
            n_rd_idx = '0;
        end else if (i_cmd.pick) begin
            n_rd_idx = CW'(r_best_idx) + CW'(1);
        end else if (issue) begin
            n_rd_idx = r_rd_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_idx <= '0;
            r_dv     <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_dv     <= issue;
        end
    end

    // payload registers: input latch, scan tracking, result
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_d_idx <= r_rd_idx[IW-1:0];
        end
        if (i_cmd.accept) begin
            r_tag      <= i_value_tag[TB-1:0];
            r_prio     <= i_prio_in;
            r_out_tag  <= '0;
            r_out_prio <= '0;
        end
        if (i_cmd.scan && r_dv && ((r_d_idx == '0) || rd_less)) begin
            r_best_tag  <= rd_tag;
            r_best_prio <= rd_prio;
            r_best_idx  <= r_d_idx;
        end
        if (i_cmd.pick) begin
            r_out_tag  <= r_best_tag;
            r_out_prio <= r_best_prio;
        end
    end

    assign o_out_tag   = 16'(r_out_tag);
    assign o_out_prio  = r_out_prio;
    assign o_occupancy = 7'(r_count);

    `UAPQ_ASSERT_ALWAYS(a_count_bound, !i_rst_n || r_count <= CW'(uapq_pkg::DEPTH), "bad count")
    `UAPQ_ASSERT(a_enq_not_full, i_cmd.enq_write |-> !o_sts.full, "append into full table")
    `UAPQ_ASSERT(a_shift_addr, (i_cmd.shift && r_dv) |-> (r_d_idx != '0), "shift below slot zero")

endmodule

// File: sv/uapq_ctrl.sv
// controller state machine of the priority queue
`include "assert_macros.svh"

module uapq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_status,
    output uapq_pkg::t_dp_cmd   o_dp_cmd,
    input  uapq_pkg::t_dp_sts   i_dp_sts
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_PICK  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    uapq_pkg::t_cmd    r_cmd, n_cmd;
    uapq_pkg::t_status r_status, n_status;
    logic              accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign accept      = i_in_valid && o_in_ready;

    // next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_status = r_status;
        o_dp_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_dp_cmd.accept = 1'b1;
                    n_cmd    = uapq_pkg::t_cmd'(i_cmd);
                    n_status = uapq_pkg::ST_OK;
                    n_state  = S_OUT;
                    unique case (i_cmd)
                        uapq_pkg::CMD_ENQ: begin
                            if (i_dp_sts.full) begin
                                n_status = uapq_pkg::ST_FULL;
                            end else begin
                                o_dp_cmd.enq_write = 1'b1;
                            end
                        end
                        uapq_pkg::CMD_DEQ, uapq_pkg::CMD_PEEK: begin
                            if (i_dp_sts.empty) begin
                                n_status = uapq_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        uapq_pkg::CMD_CHG: begin
                            if (i_dp_sts.empty) begin
                                n_status = uapq_pkg::ST_NOTFOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        uapq_pkg::CMD_CLR: begin
                            o_dp_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_dp_cmd.scan = 1'b1;
                if (r_cmd == uapq_pkg::CMD_CHG) begin
                    priority if (i_dp_sts.match) begin
                        n_state = S_OUT;
                        if (i_dp_sts.not_urgent) begin
                            n_status = uapq_pkg::ST_NOTURGENT;
                        end else begin
                            o_dp_cmd.chg_write = 1'b1;
                        end
                    end else if (i_dp_sts.scan_last) begin
                        n_state  = S_OUT;
                        n_status = uapq_pkg::ST_NOTFOUND;
                    end
                end else if (i_dp_sts.scan_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_dp_cmd.pick = 1'b1;
                n_state = (r_cmd == uapq_pkg::CMD_DEQ) ? S_SHIFT : S_OUT;
            end
            S_SHIFT: begin
                o_dp_cmd.shift = 1'b1;
                if (i_dp_sts.shift_done) begin
                    o_dp_cmd.dec_count = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmd    <= uapq_pkg::CMD_ENQ;
            r_status <= uapq_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_cmd    <= n_cmd;
            r_status <= n_status;
        end
    end

    assign o_status = r_status;

    `UAPQ_ASSERT(a_one_side, !(o_in_ready && o_out_valid), "input and result side open together")
    `UAPQ_ASSERT(a_pick_cmd, r_state == S_SHIFT |-> r_cmd == uapq_pkg::CMD_DEQ, "stray shift")
    `UAPQ_ASSERT(a_scan_done, r_state == S_PICK |=> |(r_state & (S_SHIFT | S_OUT)), "pick exit")

endmodule

// File: tb/unsorted_array_priority_queue_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the unsorted table priority queue core
module unsorted_array_priority_queue_core_tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 2 * uapq_pkg::DEPTH + 16;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int SMALL_TAG_MAX = 15;
    localparam int FILL_TAG_MAX  = 31;
    localparam int MAX_REPORTS   = 10;

    // codes outside the command set, expected to be ignored
    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

    localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] PRIO_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        uapq_pkg::t_status  status;
        logic [15:0]        tag;
        logic signed [31:0] prio;
        logic [6:0]         occ;
    } t_pq_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_cmd;
    logic [15:0]        i_value_tag;
    logic signed [31:0] i_prio_in;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [2:0]         o_status;
    logic [15:0]        o_out_tag;
    logic signed [31:0] o_out_prio;
    logic [6:0]         o_occupancy;

    // shadow copy of the queue table
    logic [uapq_pkg::TAG_BITS-1:0] pq_tags  [uapq_pkg::DEPTH];
    logic signed [31:0]            pq_prios [uapq_pkg::DEPTH];
    int                            pq_count;

    t_pq_result pending_results [$];
    bit         idle_en;
    int         fail_count;
    int         quiet_cycles;

    unsorted_array_priority_queue_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_value_tag (i_value_tag),
        .i_prio_in   (i_prio_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_out_tag   (o_out_tag),
        .o_out_prio  (o_out_prio),
        .o_occupancy (o_occupancy)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // apply one command to the shadow table and return its result
    function automatic t_pq_result apply_queue_cmd(input logic [2:0] cmd,
                                                   input logic [15:0] tag_in,
                                                   input logic signed [31:0] prio_in);
        t_pq_result                    r;
        logic [uapq_pkg::TAG_BITS-1:0] tag;
        int                            best;
        int                            i;
        bit                            found;
        r.status = uapq_pkg::ST_OK;
        r.tag    = '0;
        r.prio   = '0;
        tag      = tag_in[uapq_pkg::TAG_BITS-1:0];
        found    = 1'b0;
        case (cmd)
            uapq_pkg::CMD_ENQ: begin
                if (pq_count >= uapq_pkg::DEPTH) begin
                    r.status = uapq_pkg::ST_FULL;
                end else begin
                    pq_tags[pq_count]  = tag;
                    pq_prios[pq_count] = prio_in;
                    pq_count++;
                end
            end
            uapq_pkg::CMD_DEQ, uapq_pkg::CMD_PEEK: begin
                if (pq_count == 0) begin
                    r.status = uapq_pkg::ST_EMPTY;
                end else begin
                    // smallest priority, then smaller tag, then earliest slot
                    best = 0;
                    for (i = 1; i < pq_count; i++) begin
                        if (pq_prios[i] < pq_prios[best] ||
                            (pq_prios[i] == pq_prios[best] && pq_tags[i] < pq_tags[best]))
                            best = i;
                    end
                    r.tag  = 16'(pq_tags[best]);
                    r.prio = pq_prios[best];
                    if (cmd == uapq_pkg::CMD_DEQ) begin
                        for (i = best; i + 1 < pq_count; i++) begin
                            pq_tags[i]  = pq_tags[i + 1];
                            pq_prios[i] = pq_prios[i + 1];
                        end
                        pq_count--;
                    end
                end
            end
            uapq_pkg::CMD_CHG: begin
                // first matching tag only
                r.status = uapq_pkg::ST_NOTFOUND;
                for (i = 0; i < pq_count && !found; i++) begin
                    if (pq_tags[i] == tag) begin
                        found = 1'b1;
                        if (pq_prios[i] <= prio_in) begin
                            r.status = uapq_pkg::ST_NOTURGENT;
                        end else begin
                            r.status    = uapq_pkg::ST_OK;
                            pq_prios[i] = prio_in;
                        end
                    end
                end
            end
            uapq_pkg::CMD_CLR: pq_count = 0;
            default: ;
        endcase
        r.occ = 7'(pq_count);
        return r;
    endfunction

    // idle length: mostly short, sometimes long
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // tags from a small pool for duplicates and ties, else anything
    function automatic logic [15:0] rand_tag();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 16'($urandom_range(0, SMALL_TAG_MAX));
        if (r < 90)
            return 16'($urandom);
        return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
    endfunction

    function automatic logic signed [31:0] rand_prio();
        int r;
        int v;
        r = $urandom_range(0, 99);
        v = $urandom_range(0, 16);
        if (r < 40)
            return 32'(v - 8);
        if (r < 80)
            return 32'($urandom);
        case ($urandom_range(0, 3))
            0:       return PRIO_MIN;
            1:       return PRIO_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // a priority at or just below a stored one, clamped at the minimum
    function automatic logic signed [31:0] more_urgent_prio(input logic signed [31:0] stored);
        longint v;
        v = longint'(stored) - longint'($urandom_range(0, 2000));
        if (v < longint'(PRIO_MIN))
            v = longint'(PRIO_MIN);
        return 32'(v);
    endfunction

    // drive one command, wait for its transfer, then maybe idle
    task automatic send_cmd(input logic [2:0] cmd, input logic [15:0] tag,
                            input logic signed [31:0] prio);
        int gap;
        i_cmd       = cmd;
        i_value_tag = tag;
        i_prio_in   = prio;
        i_in_valid  = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(apply_queue_cmd(cmd, tag, prio));
        @(negedge i_clk);
        gap = (idle_en && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // empty-queue cases, field extremes, ties, change outcomes, unused codes
    task automatic test_directed();
        int c;
        idle_en = 1'b0;
        send_cmd(uapq_pkg::CMD_PEEK, 16'h0000, '0);
        send_cmd(uapq_pkg::CMD_DEQ, 16'hffff, PRIO_MAX);
        send_cmd(uapq_pkg::CMD_CHG, 16'h0005, PRIO_MIN);
        send_cmd(uapq_pkg::CMD_CLR, 16'h0000, '0);
        send_cmd(uapq_pkg::CMD_ENQ, 16'hffff, PRIO_MAX);
        send_cmd(uapq_pkg::CMD_ENQ, 16'h0000, PRIO_MIN);
        send_cmd(uapq_pkg::CMD_ENQ, 16'h0005, '0);
        send_cmd(uapq_pkg::CMD_ENQ, 16'h0003, '0);
        send_cmd(uapq_pkg::CMD_ENQ, 16'h0005, '1);
        send_cmd(uapq_pkg::CMD_PEEK, 16'h1234, PRIO_MAX);
        send_cmd(uapq_pkg::CMD_CHG, 16'h0005, '1);
        send_cmd(uapq_pkg::CMD_CHG, 16'h0005, '1);
        send_cmd(uapq_pkg::CMD_CHG, 16'h0000, 32'sd7);
        send_cmd(uapq_pkg::CMD_CHG, 16'h1234, PRIO_MIN);
        // every unused code once
        for (c = int'(CMD_RSVD_FIRST); c <= int'(CMD_RSVD_LAST); c++)
            send_cmd(3'(c), 16'hffff, PRIO_MIN);
        repeat (5) send_cmd(uapq_pkg::CMD_DEQ, 16'h0000, '0);
        send_cmd(uapq_pkg::CMD_DEQ, 16'h0000, '0);
        send_cmd(uapq_pkg::CMD_ENQ, 16'h0009, 32'sd9);
        send_cmd(uapq_pkg::CMD_CLR, 16'hffff, PRIO_MAX);
    endtask

    // fill to capacity, push past it, then drain in priority order
    task automatic test_full_table();
        int i;
        idle_en = 1'b1;
        send_cmd(uapq_pkg::CMD_CLR, rand_tag(), rand_prio());
        for (i = 0; i < uapq_pkg::DEPTH; i++)
            send_cmd(uapq_pkg::CMD_ENQ, 16'($urandom_range(0, FILL_TAG_MAX)), rand_prio());
        send_cmd(uapq_pkg::CMD_ENQ, 16'hffff, PRIO_MIN);
        send_cmd(uapq_pkg::CMD_ENQ, rand_tag(), rand_prio());
        send_cmd(uapq_pkg::CMD_PEEK, rand_tag(), rand_prio());
        send_cmd(uapq_pkg::CMD_CHG, 16'(pq_tags[uapq_pkg::DEPTH-1]),
                 more_urgent_prio(pq_prios[uapq_pkg::DEPTH-1]));
        send_cmd(uapq_pkg::CMD_CHG, 16'hffff, PRIO_MIN);
        for (i = 0; i <= uapq_pkg::DEPTH; i++)
            send_cmd(uapq_pkg::CMD_DEQ, rand_tag(), rand_prio());
    endtask

    // weighted command mix; changes mostly target tags that are present
    task automatic test_random_mix();
        int                 n;
        int                 r;
        int                 enq_w;
        int                 idx;
        logic [15:0]        tag;
        logic signed [31:0] prio;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                idle_en = ($urandom_range(0, 3) != 0);
            tag   = rand_tag();
            prio  = rand_prio();
            enq_w = (pq_count < 4) ? 60 : (pq_count > 48) ? 24 : 38;
            r     = $urandom_range(0, 99);
            if (r < enq_w) begin
                send_cmd(uapq_pkg::CMD_ENQ, tag, prio);
            end else if (r < enq_w + 20) begin
                send_cmd(uapq_pkg::CMD_DEQ, tag, prio);
            end else if (r < enq_w + 30) begin
                send_cmd(uapq_pkg::CMD_PEEK, tag, prio);
            end else if (r < enq_w + 31) begin
                send_cmd(uapq_pkg::CMD_CLR, tag, prio);
            end else if (r < enq_w + 33) begin
                send_cmd(3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)), tag, prio);
            end else begin
                if (pq_count > 0 && $urandom_range(0, 3) != 0) begin
                    idx = $urandom_range(0, pq_count - 1);
                    tag = 16'(pq_tags[idx]);
                    if ($urandom_range(0, 2) != 0)
                        prio = more_urgent_prio(pq_prios[idx]);
                end
                send_cmd(uapq_pkg::CMD_CHG, tag, prio);
            end
        end
    endtask

    // result side back-pressure
    initial begin : out_ready_drive
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                if (idle_en && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_pq_result got;
        t_pq_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.status = uapq_pkg::t_status'(o_status);
            got.tag    = o_out_tag;
            got.prio   = o_out_prio;
            got.occ    = o_occupancy;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d tag %h prio %0d occupancy %0d",
                             o_status, o_out_tag, o_out_prio, o_occupancy);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.tag !== want.tag ||
                    got.prio !== want.prio || got.occ !== want.occ) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch: expected status %0d tag %h prio %0d occ %0d",
                                 want.status, want.tag, want.prio, want.occ);
                        $display("          got      status %0d tag %h prio %0d occ %0d",
                                 o_status, o_out_tag, o_out_prio, o_occupancy);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("unsorted_array_priority_queue_core_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // reset, tests in turn, drain and verdict
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = uapq_pkg::CMD_ENQ;
        i_value_tag  = '0;
        i_prio_in    = '0;
        idle_en      = 1'b0;
        pq_count     = 0;
        fail_count   = 0;
        quiet_cycles = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_full_table();
        test_random_mix();

        i_in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("unsorted_array_priority_queue_core_tb OK");
        else
            $display("unsorted_array_priority_queue_core_tb NOT OK");
        $finish;
    end

endmodule
